@@ rtl/core/w44b_pkg.sv @@
`timescale 1ns / 1ps

package w44b_pkg;

  localparam int unsigned PoolDepth = 1391;
  localparam int unsigned AddrW     = $clog2(PoolDepth);
  localparam int unsigned WordW     = 32;
  localparam int unsigned LaneLen   = 3;

  typedef logic [AddrW-1:0] addr_t;
  typedef logic [WordW-1:0] word_t;

  localparam addr_t DepthA  = addr_t'(PoolDepth);
  localparam addr_t LastIdx = addr_t'(PoolDepth - 1);
  localparam addr_t TapA    = addr_t'(23);
  localparam addr_t TapB    = addr_t'(481);
  localparam addr_t TapC    = addr_t'(229);
  localparam addr_t OffM1   = addr_t'(PoolDepth - 1);
  localparam addr_t OffM2   = addr_t'(PoolDepth - 2);

  localparam logic [1:0] FuncSeed   = 2'd0;
  localparam logic [1:0] FuncFinish = 2'd1;
  localparam logic [1:0] FuncGen    = 2'd2;

  localparam word_t SeedMult = 32'd1812433253;
  localparam word_t MaskHi   = 32'hFFFF8000;
  localparam word_t MaskLo   = 32'h00007FFF;
  localparam word_t MaskZ2   = 32'hFBFFFFFF;
  localparam word_t TwistZ2  = 32'hB729FCEC;
  localparam word_t TempB    = 32'h93DD1400;
  localparam word_t TempC    = 32'hFA118000;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    word_t wdata;
    addr_t raddr_a;
    addr_t raddr_b;
  } mem_req_t;

endpackage

@@ rtl/core/w44b_if.sv @@
`timescale 1ns / 1ps

interface w44b_in_if import w44b_pkg::*;;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  word_t      seed_word;

  modport source (output valid, output func, output seed_word, input ready);
  modport sink (input valid, input func, input seed_word, output ready);
endinterface

interface w44b_out_if import w44b_pkg::*;;
  logic  valid;
  logic  ready;
  word_t random_word;

  modport source (output valid, output random_word, input ready);
  modport sink (input valid, input random_word, output ready);
endinterface

@@ rtl/core/well44497b_random_generator_top.sv @@
`timescale 1ns / 1ps
// WELL44497b generator with tempered output over a 1391-word pool memory.
// Input channel in_i carries func and seed_word; output channel out_o carries
// random_word. An item is taken when valid and ready are both high.
// func 0 stores a seed word; beyond 1391 words it is dropped.
// func 1 expands the pool from the loaded seed words: each expanded word runs a
// read, multiply and write step; for k seed words loaded, words k to 1390 expand.
// func 2 runs one recurrence step: ready returns and random_word turns valid
// together, once the read, write and output steps are through. The step length
// is set by the pool memory ports: six words are read over two read ports into
// two rows of tap cells, then three words are written back through the single
// write port.
// func 3 is taken and does nothing. Only func 2 produces a result item.
// After reset all 1391 pool words are swept to zero; ready stays low
// during the sweep.
// A result waits in the output register while the receiver stalls; the next
// item is still taken, and a following func 2 holds in its final step until
// the output register frees up.
module well44497b_random_generator_top import w44b_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  w44b_in_if.sink    in_i,
  w44b_out_if.source out_o
);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_RD0    = 4'd2;
  localparam logic [3:0] S_RD1    = 4'd3;
  localparam logic [3:0] S_RD2    = 4'd4;
  localparam logic [3:0] S_RD3    = 4'd5;
  localparam logic [3:0] S_WR0    = 4'd6;
  localparam logic [3:0] S_WR1    = 4'd7;
  localparam logic [3:0] S_WR2    = 4'd8;
  localparam logic [3:0] S_OUT    = 4'd9;
  localparam logic [3:0] S_EX_RD  = 4'd10;
  localparam logic [3:0] S_EX_MUL = 4'd11;
  localparam logic [3:0] S_EX_WR  = 4'd12;

  function automatic addr_t wrap_add(addr_t base, addr_t off);
    logic [AddrW:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= {1'b0, DepthA}) begin
      s = s - {1'b0, DepthA};
    end
    return s[AddrW-1:0];
  endfunction

  logic [3:0] state_q, state_d;
  addr_t      clr_q, clr_d;
  addr_t      position_q, position_d;
  addr_t      seed_count_q, seed_count_d;
  addr_t      idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  word_t      z4_q;
  word_t      prod_q;
  word_t      out_word_q;

  mem_req_t mem_req;
  word_t    rdata_a;
  word_t    rdata_b;
  word_t    lane_a [LaneLen];
  word_t    lane_b [LaneLen];
  logic     shift;
  logic     in_fire;
  logic     out_free;
  addr_t    rm1;
  addr_t    rm2;
  word_t    z0, z1, z2, z3, z2p, z2s, z4;
  word_t    tmp, tempered;
  word_t    ex_x, ex_sh;

  w44b_pool_mem u_pool (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  assign shift = (state_q == S_RD1) || (state_q == S_RD2) || (state_q == S_RD3);

  for (genvar j = 0; j < LaneLen; j++) begin : g_lane
    if (j == 0) begin : g_head
      w44b_tap_cell u_cell_a (
        .clk_i (clk_i), .shift_i (shift), .word_i (rdata_a), .word_o (lane_a[j])
      );
      w44b_tap_cell u_cell_b (
        .clk_i (clk_i), .shift_i (shift), .word_i (rdata_b), .word_o (lane_b[j])
      );
    end else begin : g_body
      w44b_tap_cell u_cell_a (
        .clk_i (clk_i), .shift_i (shift), .word_i (lane_a[j-1]), .word_o (lane_a[j])
      );
      w44b_tap_cell u_cell_b (
        .clk_i (clk_i), .shift_i (shift), .word_i (lane_b[j-1]), .word_o (lane_b[j])
      );
    end
  end

  assign in_i.ready      = (state_q == S_IDLE);
  assign in_fire         = in_i.valid && in_i.ready;
  assign out_free        = !out_valid_q || out_o.ready;
  assign out_o.valid     = out_valid_q;
  assign out_o.random_word = out_word_q;

  assign rm1 = wrap_add(position_q, OffM1);
  assign rm2 = wrap_add(position_q, OffM2);

  // lane_a: v0, m1, word at -1 ; lane_b: m2, m3, word at -2
  always_comb begin
    z0  = (MaskHi & lane_a[0]) ^ (MaskLo & lane_b[0]);
    z1  = (lane_a[2] ^ (lane_a[2] << 24)) ^ (lane_a[1] ^ (lane_a[1] >> 30));
    z2  = (lane_b[2] ^ (lane_b[2] << 10)) ^ (lane_b[1] << 26);
    z3  = z1 ^ z2;
    z2p = ((z2 << 9) ^ (z2 >> 23)) & MaskZ2;
    z2s = z2[17] ? (z2p ^ TwistZ2) : z2p;
    z4  = z0 ^ (z1 ^ (z1 >> 20)) ^ z2s ^ z3;
  end

  always_comb begin
    tmp      = z4_q ^ ((z4_q << 7) & TempB);
    tempered = tmp ^ ((tmp << 15) & TempC);
  end

  assign ex_x  = rdata_a;
  assign ex_sh = {{(WordW-2){ex_x[WordW-1]}}, ex_x[WordW-1:WordW-2]};

  always_comb begin
    mem_req = '0;
    case (state_q)
      S_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = clr_q;
      end
      S_IDLE: begin
        if (in_fire && (in_i.func == FuncSeed) && (seed_count_q < DepthA)) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = seed_count_q;
          mem_req.wdata = in_i.seed_word;
        end
      end
      S_RD0: begin
        mem_req.raddr_a = position_q;
        mem_req.raddr_b = wrap_add(position_q, TapB);
      end
      S_RD1: begin
        mem_req.raddr_a = wrap_add(position_q, TapA);
        mem_req.raddr_b = wrap_add(position_q, TapC);
      end
      S_RD2: begin
        mem_req.raddr_a = rm1;
        mem_req.raddr_b = rm2;
      end
      S_WR0: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = position_q;
        mem_req.wdata = z3;
      end
      S_WR1: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = rm1;
        mem_req.wdata = z4_q;
      end
      S_WR2: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = rm2;
        mem_req.wdata = lane_b[0] & MaskHi;
      end
      S_EX_RD: begin
        mem_req.raddr_a = idx_q - seed_count_q;
      end
      S_EX_WR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = idx_q;
        mem_req.wdata = prod_q + {{(WordW-AddrW){1'b0}}, idx_q};
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    position_d   = position_q;
    seed_count_d = seed_count_q;
    idx_d        = idx_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + addr_t'(1);
        if (clr_q == LastIdx) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          case (in_i.func)
            FuncSeed: begin
              if (seed_count_q < DepthA) begin
                seed_count_d = seed_count_q + addr_t'(1);
              end
            end
            FuncFinish: begin
              if (seed_count_q == DepthA) begin
                seed_count_d = '0;
                position_d   = '0;
              end else begin
                idx_d   = seed_count_q;
                state_d = S_EX_RD;
              end
            end
            FuncGen: state_d = S_RD0;
            default: begin
            end
          endcase
        end
      end
      S_RD0: state_d = S_RD1;
      S_RD1: state_d = S_RD2;
      S_RD2: state_d = S_RD3;
      S_RD3: state_d = S_WR0;
      S_WR0: state_d = S_WR1;
      S_WR1: state_d = S_WR2;
      S_WR2: begin
        position_d = rm1;
        state_d    = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_EX_RD:  state_d = S_EX_MUL;
      S_EX_MUL: state_d = S_EX_WR;
      S_EX_WR: begin
        if (idx_q == LastIdx) begin
          seed_count_d = '0;
          position_d   = '0;
          state_d      = S_IDLE;
        end else begin
          idx_d   = idx_q + addr_t'(1);
          state_d = S_EX_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      position_q   <= '0;
      seed_count_q <= '0;
      idx_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      position_q   <= position_d;
      seed_count_q <= seed_count_d;
      idx_q        <= idx_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_WR0) begin
      z4_q <= z4;
    end
    if (state_q == S_EX_MUL) begin
      prod_q <= word_t'((ex_x ^ ex_sh) * SeedMult);
    end
    if ((state_q == S_OUT) && out_free) begin
      out_word_q <= tempered;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) position_q < DepthA)
    else $error("position out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni) seed_count_q <= DepthA)
    else $error("seed count out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.we |-> (mem_req.waddr < DepthA))
    else $error("pool write beyond depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_OUT))
    else $error("result raised outside the output step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EX_RD) |-> (idx_q >= seed_count_q))
    else $error("expansion index below seed count");

endmodule

@@ rtl/core/w44b_pool_mem.sv @@
`timescale 1ns / 1ps

module w44b_pool_mem import w44b_pkg::*; (
  input  logic     clk_i,
  input  mem_req_t req_i,
  output word_t    rdata_a_o,
  output word_t    rdata_b_o
);

  word_t mem_q [PoolDepth];
  word_t rdata_a_q;
  word_t rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_a_q <= mem_q[req_i.raddr_a];
    rdata_b_q <= mem_q[req_i.raddr_b];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

@@ rtl/core/w44b_tap_cell.sv @@
`timescale 1ns / 1ps

module w44b_tap_cell import w44b_pkg::*; (
  input  logic  clk_i,
  input  logic  shift_i,
  input  word_t word_i,
  output word_t word_o
);

  word_t word_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      word_q <= word_i;
    end
  end

  assign word_o = word_q;

endmodule
